[rtl/core/lpf_pkg.sv]
// Shared types and constants for the length-prefixed record frame parser.
// No dependencies; every other file of the block but lpf_if imports this package.
package lpf_pkg;

  // Number of 7-bit length groups that are added into the byte count.
  localparam int LENGTH_GROUPS = 3;
  localparam int LEN_BITS      = 7;
  localparam int REMAIN_W      = LEN_BITS * LENGTH_GROUPS;
  localparam int GROUP_W       = $clog2(LENGTH_GROUPS + 1);
  localparam int POS_W         = 4;

  // Byte codes of the stream.
  localparam logic [7:0] START_LIMIT = 8'h80;
  localparam logic [7:0] LEN_MASK    = 8'h7F;
  localparam logic [7:0] ACK_BYTE    = 8'h31;
  localparam logic [7:0] RECORD_TYPE = 8'h31;
  localparam logic [7:0] CAT_CODE_A  = 8'h0C;
  localparam logic [7:0] CAT_CODE_B  = 8'h02;
  localparam logic [7:0] CAT_MARK    = 8'h80;
  localparam logic [1:0] VALUE_HI_MASK = 2'h3;

  // Data positions inside a record frame.
  localparam logic [POS_W-1:0] POS_COUNT_LO = 4'd1;
  localparam logic [POS_W-1:0] POS_COUNT_HI = 4'd2;
  localparam logic [POS_W-1:0] POS_CATEGORY = 4'd3;
  localparam logic [POS_W-1:0] POS_MARK     = 4'd4;
  localparam logic [POS_W-1:0] POS_TIME_A   = 4'd5;
  localparam logic [POS_W-1:0] POS_TIME_A_E = 4'd8;
  localparam logic [POS_W-1:0] POS_TIME_B   = 4'd9;
  localparam logic [POS_W-1:0] POS_TIME_B_E = 4'd12;
  localparam logic [POS_W-1:0] POS_VALUE_LO = 4'd13;
  localparam logic [POS_W-1:0] POS_VALUE_HI = 4'd14;
  localparam logic [POS_W-1:0] POS_MAX      = 4'd15;

  // Parser phase.
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LEN  = 2'd1,
    PH_TYPE = 2'd2,
    PH_DATA = 2'd3
  } phase_t;

  // Control from the framing state machine to the record accumulator.
  typedef struct packed {
    logic             accept;
    logic             ack;
    logic             take_type;
    logic             data_byte;
    logic [POS_W-1:0] data_pos;
  } ctl_t;

  // One result transaction.
  typedef struct packed {
    logic        ack_seen;
    logic        record_valid;
    logic        record_category;
    logic [9:0]  record_value;
    logic [15:0] record_count;
    logic [31:0] record_time;
  } result_t;

endpackage

[rtl/core/lpf_if.sv]
// Valid/ready stream interfaces for the input bytes and the parser results.
// No dependencies; the field widths are written out in the interfaces.
interface lpf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lpf_out_if;
  logic        valid;
  logic        ready;
  logic        ack_seen;
  logic        record_valid;
  logic        record_category;
  logic [9:0]  record_value;
  logic [15:0] record_count;
  logic [31:0] record_time;

  modport source (output valid, output ack_seen, output record_valid,
                  output record_category, output record_value,
                  output record_count, output record_time, input ready);
  modport sink   (input valid, input ack_seen, input record_valid,
                  input record_category, input record_value,
                  input record_count, input record_time, output ready);
endinterface

[rtl/core/lpf_frame_fsm.sv]
// Framing state machine: idle, length groups, type byte and data countdown.
// Depends on lpf_pkg; drives the control struct for lpf_record_acc.
module lpf_frame_fsm (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [7:0]    rx_byte,
  output lpf_pkg::ctl_t ctl
);
  import lpf_pkg::*;

  phase_t              phase_r, phase_nxt;
  logic [REMAIN_W-1:0] remain_r, remain_nxt;
  logic [GROUP_W-1:0]  group_r, group_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic                cont_byte;
  logic [REMAIN_W-1:0] len_low;
  logic [REMAIN_W-1:0] len_addend;

  // A byte above 0x80 continues (or starts) the length field.
  assign cont_byte  = (rx_byte > START_LIMIT);
  assign len_low    = REMAIN_W'(rx_byte & LEN_MASK);
  assign len_addend = len_low << (LEN_BITS * int'(group_r));

  // Next-state logic.
  always_comb begin
    phase_nxt  = phase_r;
    remain_nxt = remain_r;
    group_nxt  = group_r;
    pos_nxt    = pos_r;
    case (phase_r)
      PH_IDLE: begin
        if (cont_byte) begin
          phase_nxt  = PH_LEN;
          remain_nxt = len_low;
          group_nxt  = GROUP_W'(1);
        end
      end
      PH_LEN: begin
        if (cont_byte) begin
          if (group_r < GROUP_W'(LENGTH_GROUPS)) begin
            remain_nxt = remain_r + len_addend;
            group_nxt  = group_r + GROUP_W'(1);
          end
        end else begin
          phase_nxt = PH_DATA;
          pos_nxt   = '0;
        end
      end
      PH_TYPE: begin
        phase_nxt = PH_DATA;
        pos_nxt   = '0;
      end
      PH_DATA: begin
        if (pos_r < POS_MAX) begin
          pos_nxt = pos_r + POS_W'(1);
        end
        if (remain_r <= REMAIN_W'(1)) begin
          remain_nxt = '0;
          phase_nxt  = PH_IDLE;
          pos_nxt    = '0;
          group_nxt  = '0;
        end else begin
          remain_nxt = remain_r - REMAIN_W'(1);
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // Output logic toward the record accumulator.
  always_comb begin
    ctl.accept    = accept;
    ctl.ack       = 1'b0;
    ctl.take_type = 1'b0;
    ctl.data_byte = 1'b0;
    ctl.data_pos  = pos_r;
    case (phase_r)
      PH_IDLE: ctl.ack       = !cont_byte && (rx_byte == ACK_BYTE);
      PH_LEN:  ctl.take_type = !cont_byte;
      PH_TYPE: ctl.take_type = 1'b1;
      PH_DATA: ctl.data_byte = 1'b1;
      default: ctl.ack       = 1'b0;
    endcase
  end

  // State registers advance once per accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      remain_r <= '0;
      group_r  <= '0;
      pos_r    <= '0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      remain_r <= remain_nxt;
      group_r  <= group_nxt;
      pos_r    <= pos_nxt;
    end
  end

endmodule

[rtl/core/lpf_record_acc.sv]
// Record field accumulator: frame type, count, category, time and value.
// Depends on lpf_pkg; controlled by lpf_frame_fsm, feeds the output register.
module lpf_record_acc (
  input  logic             clk,
  input  lpf_pkg::ctl_t    ctl,
  input  logic [7:0]       rx_byte,
  output lpf_pkg::result_t result
);
  import lpf_pkg::*;

  logic [7:0]  kind_r, kind_nxt;
  logic        cat_ok_r, cat_ok_nxt;
  logic        cat_sel_r, cat_sel_nxt;
  logic [9:0]  value_r, value_nxt;
  logic [15:0] count_r, count_nxt;
  logic [31:0] time_r, time_nxt;
  logic [1:0]  lane_a;
  logic [1:0]  lane_b;
  logic        emit;

  assign lane_a = 2'(ctl.data_pos - POS_TIME_A);
  assign lane_b = 2'(ctl.data_pos - POS_TIME_B);

  // Field updates for the current byte.
  always_comb begin
    kind_nxt    = kind_r;
    cat_ok_nxt  = cat_ok_r;
    cat_sel_nxt = cat_sel_r;
    value_nxt   = value_r;
    count_nxt   = count_r;
    time_nxt    = time_r;
    emit        = 1'b0;
    if (ctl.take_type) begin
      kind_nxt   = rx_byte;
      cat_ok_nxt = 1'b0;
    end else if (ctl.data_byte && (kind_r == RECORD_TYPE)) begin
      case (ctl.data_pos) inside
        POS_COUNT_LO: count_nxt = {count_r[15:8], rx_byte};
        POS_COUNT_HI: count_nxt = {rx_byte, count_r[7:0]};
        POS_CATEGORY: begin
          cat_ok_nxt  = (rx_byte == CAT_CODE_A) || (rx_byte == CAT_CODE_B);
          cat_sel_nxt = (rx_byte == CAT_CODE_B);
        end
        POS_MARK: begin
          if (rx_byte != CAT_MARK) begin
            cat_ok_nxt = 1'b0;
          end
        end
        [POS_TIME_A:POS_TIME_A_E]: begin
          time_nxt = (time_r & ~(32'hFF << (8 * int'(lane_a))))
                   | (32'(rx_byte) << (8 * int'(lane_a)));
        end
        [POS_TIME_B:POS_TIME_B_E]: begin
          time_nxt = time_r + (32'(rx_byte) << (8 * int'(lane_b)));
        end
        POS_VALUE_LO: value_nxt = {value_r[9:8], rx_byte};
        POS_VALUE_HI: begin
          value_nxt = {rx_byte[1:0] & VALUE_HI_MASK, value_r[7:0]};
          emit      = cat_ok_r && (value_nxt != '0);
        end
        default: emit = 1'b0;
      endcase
    end
  end

  // Result of this transaction; record fields read as zero when not emitted.
  always_comb begin
    result.ack_seen        = ctl.ack;
    result.record_valid    = emit;
    result.record_category = emit ? cat_sel_r : 1'b0;
    result.record_value    = emit ? value_nxt : '0;
    result.record_count    = emit ? count_r : '0;
    result.record_time     = emit ? time_r : '0;
  end

  // Every field is written before it is read within a frame.
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      kind_r    <= kind_nxt;
      cat_ok_r  <= cat_ok_nxt;
      cat_sel_r <= cat_sel_nxt;
      value_r   <= value_nxt;
      count_r   <= count_nxt;
      time_r    <= time_nxt;
    end
  end

endmodule

[rtl/core/length_prefixed_record_frame_parser.sv]
// Length-prefixed record frame parser, top level.
// Each accepted byte's result is registered in the output register, which frees as
// its result is taken. Throughput: one byte per cycle while out_ch is not stalled.
// Reset: synchronous active-low rst_n returns the parser to idle and empties
// the output register; no clearing pass is needed.
// Depends on lpf_pkg, lpf_if, lpf_frame_fsm and lpf_record_acc.
module length_prefixed_record_frame_parser (
  input  logic           clk,
  input  logic           rst_n,
  lpf_in_if.sink         in_ch,
  lpf_out_if.source      out_ch
);
  import lpf_pkg::*;

  logic    accept;
  ctl_t    ctl;
  result_t result;
  logic    out_valid_r;
  result_t out_data_r;

  // A byte is taken whenever the output register is empty or being drained.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  lpf_frame_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .rx_byte (in_ch.rx_byte),
    .ctl     (ctl)
  );

  lpf_record_acc u_acc (
    .clk     (clk),
    .ctl     (ctl),
    .rx_byte (in_ch.rx_byte),
    .result  (result)
  );

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= result;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.ack_seen        = out_data_r.ack_seen;
  assign out_ch.record_valid    = out_data_r.record_valid;
  assign out_ch.record_category = out_data_r.record_category;
  assign out_ch.record_value    = out_data_r.record_value;
  assign out_ch.record_count    = out_data_r.record_count;
  assign out_ch.record_time     = out_data_r.record_time;

endmodule

[tb/sv/length_prefixed_record_frame_parser_tb.sv]
// Self-checking testbench for the length-prefixed record frame parser.
// Drives byte streams of directed and random frames, predicts every result and compares.
// Depends on lpf_pkg, lpf_if and the length_prefixed_record_frame_parser RTL.
module length_prefixed_record_frame_parser_tb;
  import lpf_pkg::*;

  // Category encoding of the predicted parser state: code A, code B, or no valid category.
  localparam logic [7:0] CAT_SEL_A    = 8'd0;
  localparam logic [7:0] CAT_SEL_B    = 8'd1;
  localparam logic [7:0] CAT_INVALID  = 8'hFF;
  localparam int         MAX_REPORTS  = 10;
  localparam int         IDLE_PERCENT = 13;

  logic clk = 1'b0;
  logic rst_n;

  lpf_in_if  in_ch ();
  lpf_out_if out_ch ();

  length_prefixed_record_frame_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Parser state as predicted from the accepted byte stream.
  phase_t              frame_phase  = PH_IDLE;
  logic [REMAIN_W-1:0] bytes_left   = '0;
  int unsigned         group_index  = 0;
  logic [POS_W-1:0]    data_slot    = '0;
  logic [7:0]          frame_type   = '0;
  logic [7:0]          category_sel = '0;
  logic [9:0]          value_acc    = '0;
  logic [15:0]         count_acc    = '0;
  logic [31:0]         stamp_acc    = '0;

  result_t     predicted_results[$];
  int unsigned bytes_sent   = 0;
  int unsigned error_count  = 0;
  bit          steady_flow  = 1'b0;
  int          stall_left   = 0;

  // The type byte opens the data phase and invalidates the category.
  function automatic void open_data_phase(input logic [7:0] b);
    frame_type   = b;
    frame_phase  = PH_DATA;
    data_slot    = '0;
    category_sel = CAT_INVALID;
  endfunction

  // Advances the predicted parser state by one byte and returns its result.
  function automatic result_t parse_byte(input logic [7:0] b);
    result_t r;
    r = '0;
    case (frame_phase)
      PH_IDLE: begin
        if (b > START_LIMIT) begin
          frame_phase = PH_LEN;
          bytes_left  = REMAIN_W'(b & LEN_MASK);
          group_index = 1;
        end else if (b == ACK_BYTE) begin
          r.ack_seen = 1'b1;
        end
      end
      PH_LEN: begin
        if (b > START_LIMIT) begin
          // Groups past the configured count keep the length phase going but add nothing.
          if (group_index < LENGTH_GROUPS) begin
            bytes_left = bytes_left + (REMAIN_W'(b & LEN_MASK) << (LEN_BITS * group_index));
            group_index++;
          end
        end else begin
          open_data_phase(b);
        end
      end
      PH_TYPE: begin
        open_data_phase(b);
      end
      default: begin
        if (frame_type == RECORD_TYPE) begin
          if (data_slot == POS_COUNT_LO) begin
            count_acc[7:0] = b;
          end else if (data_slot == POS_COUNT_HI) begin
            count_acc[15:8] = b;
          end else if (data_slot == POS_CATEGORY) begin
            category_sel = (b == CAT_CODE_A) ? CAT_SEL_A :
                           (b == CAT_CODE_B) ? CAT_SEL_B : CAT_INVALID;
          end else if (data_slot == POS_MARK) begin
            if (b != CAT_MARK) category_sel = CAT_INVALID;
          end else if (data_slot >= POS_TIME_A && data_slot <= POS_TIME_A_E) begin
            stamp_acc[8 * (data_slot - POS_TIME_A) +: 8] = b;
          end else if (data_slot >= POS_TIME_B && data_slot <= POS_TIME_B_E) begin
            stamp_acc = stamp_acc + (32'(b) << (8 * (data_slot - POS_TIME_B)));
          end else if (data_slot == POS_VALUE_LO) begin
            value_acc[7:0] = b;
          end else if (data_slot == POS_VALUE_HI) begin
            value_acc[9:8] = b[1:0] & VALUE_HI_MASK;
            if (category_sel != CAT_INVALID && value_acc != '0) begin
              r.record_valid    = 1'b1;
              r.record_category = category_sel[0];
              r.record_value    = value_acc;
              r.record_count    = count_acc;
              r.record_time     = stamp_acc;
            end
          end
        end
        if (data_slot < POS_MAX) data_slot++;
        // The last data byte closes the frame.
        if (bytes_left <= 1) begin
          bytes_left  = '0;
          frame_phase = PH_IDLE;
          data_slot   = '0;
          group_index = 0;
        end else begin
          bytes_left--;
        end
      end
    endcase
    return r;
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Offers one byte, with random gaps, and records its expected result on acceptance.
  task automatic send_byte(input logic [7:0] b);
    while (!steady_flow && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted_results.push_back(parse_byte(b));
    bytes_sent++;
  endtask

  task automatic send_filler(input int unsigned n);
    repeat (n) send_byte(any_byte());
  endtask

  // Sends a record frame of 15 + filler data bytes with the given record content.
  task automatic send_record(input logic [7:0] cat_byte, input logic [7:0] mark_byte,
                             input logic [15:0] rec_count, input logic [31:0] word_a,
                             input logic [31:0] word_b, input logic [9:0] rec_value,
                             input int unsigned filler);
    logic [7:0] value_hi;
    value_hi = {6'($urandom_range(0, 63)), rec_value[9:8]};
    send_byte(START_LIMIT | 8'(15 + filler));
    send_byte(RECORD_TYPE);
    send_byte(any_byte());
    send_byte(rec_count[7:0]);
    send_byte(rec_count[15:8]);
    send_byte(cat_byte);
    send_byte(mark_byte);
    for (int i = 0; i < 4; i++) send_byte(word_a[8 * i +: 8]);
    for (int i = 0; i < 4; i++) send_byte(word_b[8 * i +: 8]);
    send_byte(rec_value[7:0]);
    send_byte(value_hi);
    send_filler(filler);
  endtask

  // One random frame: mostly well-formed records, the rest other frames and noise.
  task automatic send_random_frame();
    int unsigned pick;
    int unsigned len;
    int unsigned r;
    logic [7:0]  cat_byte;
    logic [7:0]  mark_byte;
    logic [9:0]  rec_value;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      r = $urandom_range(0, 19);
      cat_byte  = (r < 9) ? CAT_CODE_A : (r < 18) ? CAT_CODE_B : any_byte();
      mark_byte = ($urandom_range(0, 9) == 0) ? any_byte() : CAT_MARK;
      rec_value = ($urandom_range(0, 9) == 0) ? 10'd0 : 10'($urandom_range(0, 1023));
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(4, 112) : $urandom_range(0, 3);
      send_record(cat_byte, mark_byte, 16'($urandom), $urandom, $urandom, rec_value, len);
    end else if (pick < 65) begin
      // Frame of a random type, which may also be the record type.
      len = $urandom_range(1, 20);
      send_byte(START_LIMIT | 8'(len));
      send_byte(8'($urandom_range(0, 128)));
      send_filler(len);
    end else if (pick < 75) begin
      // Record frame cut short before the high value byte.
      len = $urandom_range(1, 14);
      send_byte(START_LIMIT | 8'(len));
      send_byte(RECORD_TYPE);
      send_filler(len);
    end else if (pick < 82) begin
      // Two length groups.
      len = $urandom_range(1, 15);
      send_byte(START_LIMIT | 8'(len));
      send_byte(START_LIMIT | 8'd1);
      send_byte(($urandom_range(0, 2) == 0) ? RECORD_TYPE : 8'($urandom_range(0, 128)));
      send_filler(len + 128);
    end else begin
      // Idle noise and acknowledge bytes.
      repeat ($urandom_range(1, 4)) begin
        send_byte(($urandom_range(0, 3) == 0) ? ACK_BYTE : 8'($urandom_range(0, 128)));
      end
    end
  endtask

  // Stops offering and waits until every predicted result has been taken.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_idle_bytes();
    send_byte(ACK_BYTE);
    send_byte(8'h00);
    send_byte(START_LIMIT);
    send_byte(8'h7F);
    send_byte(8'h30);
    send_byte(ACK_BYTE);
    drain_results();
  endtask

  task automatic test_record_fields();
    // Field extremes; the two time words of the first record wrap to zero.
    send_record(CAT_CODE_A, CAT_MARK, 16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0001, 10'h3FF, 0);
    send_record(CAT_CODE_B, CAT_MARK, 16'h0000, 32'h1234_5678, 32'hF000_0000, 10'h001, 2);
    // Rejected records: wrong mark byte, unknown category code, zero value.
    send_record(CAT_CODE_A, 8'h00, 16'h5A5A, 32'h0, 32'h0, 10'h155, 0);
    send_record(8'h03, CAT_MARK, 16'hA5A5, 32'h0, 32'h0, 10'h2AA, 0);
    send_record(CAT_CODE_B, CAT_MARK, 16'h1234, 32'h1, 32'h1, 10'h000, 1);
    drain_results();
  endtask

  task automatic test_frame_lengths();
    // Longest single-group frame of a non-record type.
    send_byte(8'hFF);
    send_byte(8'h00);
    send_filler(127);
    // A 0x80 byte after the length is the type; a single data byte ends the frame.
    send_byte(START_LIMIT | 8'd1);
    send_byte(START_LIMIT);
    send_byte(any_byte());
    // Short record frame, then a non-record frame with record-shaped content.
    send_byte(START_LIMIT | 8'd5);
    send_byte(RECORD_TYPE);
    send_filler(5);
    send_byte(START_LIMIT | 8'd15);
    send_byte(8'h30);
    send_byte(8'h00);
    send_byte(8'h11);
    send_byte(8'h22);
    send_byte(CAT_CODE_A);
    send_byte(CAT_MARK);
    send_filler(10);
    drain_results();
  endtask

  // A long stretch with neither side idling.
  task automatic test_steady_stream();
    steady_flow = 1'b1;
    repeat (12) send_random_frame();
    drain_results();
    steady_flow = 1'b0;
  endtask

  // The receiver holds off while bytes keep coming, so the input stalls.
  task automatic test_backpressure();
    stall_left = 200;
    repeat (4) send_random_frame();
    drain_results();
  endtask

  task automatic test_random_frames();
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < 300) send_random_frame();
    drain_results();
  endtask

  // Three length groups, then continuation bytes past the last group that are not added.
  // The frame holds over sixteen thousand data bytes, so only its record and a few
  // more bytes are sent; the frame is still open when the run ends.
  task automatic test_ignored_length_groups();
    send_byte(START_LIMIT | 8'd1);
    send_byte(START_LIMIT | 8'd1);
    send_byte(START_LIMIT | 8'd1);
    send_byte(8'hFF);
    send_byte(8'hC3);
    send_byte(RECORD_TYPE);
    send_byte(any_byte());
    send_byte(8'h34);
    send_byte(8'h12);
    send_byte(CAT_CODE_B);
    send_byte(CAT_MARK);
    for (int i = 0; i < 8; i++) send_byte(any_byte());
    send_byte(8'h2D);
    send_byte(8'h01);
    send_filler(4);
    drain_results();
  endtask

  // Receiver ready: random stalls, a counted hold-off on request, or always ready.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (steady_flow) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  // Compare each result transaction with the oldest prediction.
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (predicted_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS) $display("Unexpected result transaction at %0t", $time);
      end else begin
        want = predicted_results.pop_front();
        if (out_ch.ack_seen !== want.ack_seen ||
            out_ch.record_valid !== want.record_valid ||
            out_ch.record_category !== want.record_category ||
            out_ch.record_value !== want.record_value ||
            out_ch.record_count !== want.record_count ||
            out_ch.record_time !== want.record_time) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("Mismatch at %0t: expected ack=%0b valid=%0b cat=%0b value=%h count=%h time=%h",
                     $time, want.ack_seen, want.record_valid, want.record_category,
                     want.record_value, want.record_count, want.record_time);
            $display("                  actual ack=%0b valid=%0b cat=%0b value=%h count=%h time=%h",
                     out_ch.ack_seen, out_ch.record_valid, out_ch.record_category,
                     out_ch.record_value, out_ch.record_count, out_ch.record_time);
          end
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'h00;
    out_ch.ready  = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_bytes();
    test_record_fields();
    test_frame_lengths();
    test_steady_stream();
    test_backpressure();
    test_random_frames();
    test_ignored_length_groups();

    drain_results();
    repeat (4) @(posedge clk);
    error_count += predicted_results.size();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
